>>> design/work_stealing_deque_macros.svh
// Assertion macros shared by the deque RTL.
// WSD_ASSERT checks a property outside reset; WSD_ASSERT_RST also checks it while reset is held.
`ifndef WORK_STEALING_DEQUE_MACROS_SVH
`define WORK_STEALING_DEQUE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define WSD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("deque assertion failed");

`define WSD_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("deque reset assertion failed");

`else

`define WSD_ASSERT(name, clk, rstn, prop)

`define WSD_ASSERT_RST(name, clk, prop)

`endif

`endif

>>> design/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

  localparam int unsigned TASK_W = 32;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned OCC_W  = 7;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_TAKE  = 2'd1,
    MODE_STEAL = 2'd2,
    MODE_PEEK  = 2'd3
  } wsd_mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } wsd_status_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2,
    ST_RESP  = 2'd3
  } wsd_state_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TASK_W-1:0] task_in;
    logic [IDX_W-1:0]  peek_index;
  } wsd_in_t;

  typedef struct packed {
    logic [TASK_W-1:0] task_out;
    logic [1:0]        status;
    logic [OCC_W-1:0]  occupancy;
  } wsd_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic execute;
  } wsd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } wsd_stat_t;

endpackage

`default_nettype wire

>>> design/work_stealing_deque.sv
// Work-stealing deque of task handles in a ring of DEPTH slots.
// Input channel: in_valid_i / in_stall_o carry one word of mode, task_in and peek_index.
// Mode push adds a task at the bottom, take removes the newest task from the bottom, steal
// removes the oldest task from the top, and peek reads one raw slot by index.
// Output channel: out_valid_o / out_stall_i carry one word per input word, giving
// the task handle, a status code (ok, empty, full, out of range) and the occupancy after it.
// A word is captured when accepted, executed in the EXEC state (one access to the slot
// memory), and its result is shown from the RESP state onward.
// The next word is accepted in the same cycle the previous result is taken, so a new word
// does not enter until the last result leaves.
// When the receiver stalls, the result word holds and the input stays stalled.
// After reset the block sweeps all DEPTH slots of the memory to zero, one slot a cycle;
// during this pass the input is stalled and no result is shown.
`default_nettype none

module work_stealing_deque #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned TASK_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wsd_pkg::wsd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wsd_pkg::wsd_out_t out_data_o
);
  import wsd_pkg::*;

  wsd_cmd_t  cmd;
  wsd_stat_t stat;

  // The controller sequences clear, accept, execute and respond.
  wsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // The datapath holds the indices, the slot memory and the result registers.
  wsd_dp #(
    .DEPTH      (DEPTH),
    .TASK_WIDTH (TASK_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> design/wsd_ctrl.sv
`default_nettype none
`include "work_stealing_deque_macros.svh"

module wsd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wsd_pkg::wsd_cmd_t cmd_o,
  input  wsd_pkg::wsd_stat_t stat_i
);
  import wsd_pkg::*;

  wsd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          // The result leaves this cycle, so the next word may enter.
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_EXEC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  `WSD_ASSERT_RST(a_reset_clear, clk_i, !rst_ni |-> state_q == ST_CLEAR)
  `WSD_ASSERT(a_accept_exec, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> state_q == ST_EXEC)
  `WSD_ASSERT(a_exec_resp, clk_i, rst_ni, state_q == ST_EXEC |=> out_valid_o)

endmodule

`default_nettype wire

>>> design/wsd_dp.sv
`default_nettype none
`include "work_stealing_deque_macros.svh"

module wsd_dp #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned TASK_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wsd_pkg::wsd_cmd_t  cmd_i,
  output wsd_pkg::wsd_stat_t stat_o,
  input  wsd_pkg::wsd_in_t   in_data_i,
  output wsd_pkg::wsd_out_t  out_data_o
);
  import wsd_pkg::*;

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned PW      = $clog2(2 * DEPTH);
  localparam int unsigned CW      = (PW > IDX_W) ? PW : IDX_W;
  localparam int unsigned MW      = (TASK_WIDTH < TASK_W) ? TASK_WIDTH : TASK_W;
  localparam logic [PW-1:0] POS_MAX = PW'(2 * DEPTH - 1);

  // Task ring and its registered read port.
  logic [TASK_WIDTH-1:0] mem_q [DEPTH];
  logic [TASK_WIDTH-1:0] rdata_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [TASK_WIDTH-1:0] mem_wdata;

  logic [PW-1:0]   top_q, top_d, bot_q, bot_d;
  logic [AW-1:0]   clr_q;
  wsd_mode_e       op_q;
  logic [TASK_W-1:0] task_q;
  logic [IDX_W-1:0]  idx_q;
  wsd_status_e     status_q, status_d;
  logic            hit_q, hit_d;

  logic [PW-1:0]   held_w;
  logic            full_w, empty_w;
  logic            push_ok_w;
  logic [PW-1:0]   bot_prev_w, bot_next_w, top_next_w;
  logic [CW-1:0]   idx_c, dep_c;

  function automatic logic [AW-1:0] pos_slot(input logic [PW-1:0] p);
    logic [AW-1:0] s;
    if (p >= PW'(DEPTH)) begin
      s = AW'(p - PW'(DEPTH));
    end else begin
      s = AW'(p);
    end
    return s;
  endfunction

  function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p);
    return (p == POS_MAX) ? '0 : p + PW'(1);
  endfunction

  // Positions run modulo 2*DEPTH; a wrapped difference is formed one bit wider.
  assign held_w  = (bot_q >= top_q) ? bot_q - top_q
                 : PW'({1'b0, bot_q} + (PW + 1)'(2 * DEPTH) - {1'b0, top_q});
  assign full_w  = (held_w == PW'(DEPTH));
  assign empty_w = (held_w == '0);
  assign push_ok_w = cmd_i.execute && (op_q == MODE_PUSH) && !full_w;
  assign bot_prev_w = (bot_q == '0) ? POS_MAX : bot_q - PW'(1);
  assign bot_next_w = pos_next(bot_q);
  assign top_next_w = pos_next(top_q);
  assign idx_c = CW'(idx_q);
  assign dep_c = CW'(DEPTH);

  assign stat_o.clear_last = (clr_q == AW'(DEPTH - 1));

  always_comb begin
    top_d     = top_q;
    bot_d     = bot_q;
    status_d  = status_q;
    hit_d     = hit_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clr_q;
    mem_raddr = '0;
    mem_wdata = '0;
    if (cmd_i.clear_en) begin
      mem_we = 1'b1;
    end else if (cmd_i.execute) begin
      status_d = STAT_OK;
      hit_d    = 1'b0;
      case (op_q)
        MODE_PUSH: begin
          if (full_w) begin
            status_d = STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pos_slot(bot_q);
            mem_wdata[MW-1:0] = task_q[MW-1:0];
            bot_d     = bot_next_w;
          end
        end
        MODE_TAKE: begin
          if (empty_w) begin
            status_d = STAT_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_slot(bot_prev_w);
            bot_d     = bot_prev_w;
            hit_d     = 1'b1;
          end
        end
        MODE_STEAL: begin
          if (empty_w) begin
            status_d = STAT_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_slot(top_q);
            top_d     = top_next_w;
            hit_d     = 1'b1;
          end
        end
        MODE_PEEK: begin
          if (idx_c > dep_c) begin
            status_d = STAT_RANGE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = (idx_c == dep_c) ? '0 : AW'(idx_c);
            hit_d     = 1'b1;
          end
        end
        default: begin
          status_d = STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= '0;
      bot_q    <= '0;
      clr_q    <= '0;
      status_q <= STAT_OK;
      hit_q    <= 1'b0;
    end else begin
      top_q    <= top_d;
      bot_q    <= bot_d;
      status_q <= status_d;
      hit_q    <= hit_d;
      if (cmd_i.clear_en) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= wsd_mode_e'(in_data_i.mode);
      task_q <= in_data_i.task_in;
      idx_q  <= in_data_i.peek_index;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    out_data_o.task_out = '0;
    if (hit_q) begin
      out_data_o.task_out[MW-1:0] = rdata_q[MW-1:0];
    end
    out_data_o.status    = status_q;
    out_data_o.occupancy = OCC_W'(held_w);
  end

  `WSD_ASSERT(a_held_bound, clk_i, rst_ni, held_w <= PW'(DEPTH))
  `WSD_ASSERT(a_pos_range, clk_i, rst_ni, (top_q <= POS_MAX) && (bot_q <= POS_MAX))
  `WSD_ASSERT(a_push_grows, clk_i, rst_ni, push_ok_w |=> held_w == $past(held_w) + PW'(1))

endmodule

`default_nettype wire
